/* hw/rtl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants of the ball shot detector.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int WindowDepthDefault = 20;

    localparam logic [15:0] DistanceScaleReset  = 16'd256;
    localparam logic [11:0] WidthThresholdReset = 12'd10;
    localparam logic [5:0]  MinSpanReset        = 6'd5;
    localparam logic [7:0]  FrameRateReset      = 8'd45;
    localparam logic [15:0] SpeedThresholdReset = 16'd1000;
    localparam logic [4:0]  HoldFramesReset     = 5'd21;

    // register indexes
    localparam logic [2:0] RegDistanceScale  = 3'd0;
    localparam logic [2:0] RegWidthThreshold = 3'd1;
    localparam logic [2:0] RegMinSpan        = 3'd2;
    localparam logic [2:0] RegFrameRate      = 3'd3;
    localparam logic [2:0] RegSpeedThreshold = 3'd4;
    localparam logic [2:0] RegHoldFrames     = 3'd5;

    // verdict codes
    localparam logic [1:0] VerdictIdle   = 2'd0;
    localparam logic [1:0] VerdictHeld   = 2'd1;
    localparam logic [1:0] VerdictNearer = 2'd2;

    // one window entry: x, y, width
    typedef struct packed {
        logic [11:0] w;
        logic [15:0] y;
        logic [15:0] x;
    } hist_entry_t;

endpackage

/* hw/rtl/ball_shot_detector.sv */
// ----------------------------------------------------------------------------
// ball_shot_detector
// Shot detection from a window of recent ball sightings.
// ----------------------------------------------------------------------------
// Usage: one frame enters as a beat on s_axis (robot and ball positions and
// the ball width); one result beat leaves on m_axis per frame (verdict, hold
// count and latched shot start point). The user must write registers on the
// cfg channel only while the block is idle; the block itself does not enforce
// this. The window lives in a ring memory with one read port. A frame is
// written at the ring head. The entries are then read newest to oldest, and
// each goes through a read state and a look state. Each valid segment length
// then goes through a bit-serial square root of 17 steps. Only one frame is
// worked on at a time. Reset clears the control state and all widths
// through a valid bit per ring entry, so no clearing pass is needed. When
// the receiver stalls the result is held in the output register and the next
// frame is not taken until that beat leaves.
// ----------------------------------------------------------------------------
module ball_shot_detector #(
    parameter int WINDOW_DEPTH = bsd_pkg::WindowDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // robot_x[15:0], robot_y[31:16], ball_x[47:32], ball_y[63:48],
    // ball_width[75:64], zero fill [79:76]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // verdict[1:0], hold_count[6:2], shot_start_x[22:7], shot_start_y[38:23],
    // zero fill [39]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IdxW = $clog2(WINDOW_DEPTH);
    localparam int CntW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_SQRT  = 8'b0000_1000,
        ST_MUL1  = 8'b0001_0000,
        ST_MUL2  = 8'b0010_0000,
        ST_DECIDE= 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] dscale_reg;
    logic [11:0] wthr_reg;
    logic [5:0]  mspan_reg;
    logic [7:0]  frate_reg;
    logic [15:0] sthr_reg;
    logic [4:0]  hframes_reg;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dscale_reg  <= bsd_pkg::DistanceScaleReset;
            wthr_reg    <= bsd_pkg::WidthThresholdReset;
            mspan_reg   <= bsd_pkg::MinSpanReset;
            frate_reg   <= bsd_pkg::FrameRateReset;
            sthr_reg    <= bsd_pkg::SpeedThresholdReset;
            hframes_reg <= bsd_pkg::HoldFramesReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bsd_pkg::RegDistanceScale:  dscale_reg  <= cfg_data;
                bsd_pkg::RegWidthThreshold: wthr_reg    <= cfg_data[11:0];
                bsd_pkg::RegMinSpan:        mspan_reg   <= cfg_data[5:0];
                bsd_pkg::RegFrameRate:      frate_reg   <= cfg_data[7:0];
                bsd_pkg::RegSpeedThreshold: sthr_reg    <= cfg_data;
                bsd_pkg::RegHoldFrames:     hframes_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ring memory and per-entry valid bits
    bsd_pkg::hist_entry_t ring_mem [WINDOW_DEPTH];
    bsd_pkg::hist_entry_t rd_data_reg;
    logic [WINDOW_DEPTH-1:0] ring_vld_reg;
    logic                    rd_vld_reg;
    logic [IdxW-1:0]         head_reg;
    logic [IdxW-1:0]         rd_addr;
    logic                    mem_we;
    logic                    mem_re;
    logic [CntW-1:0]         iss_reg, iss_next;    // next window index to read
    logic [CntW-1:0]         pos_reg, pos_next;    // window index of rd_data_reg

    // frame fields
    logic signed [15:0] rx_reg, ry_reg, bx_reg, by_reg;

    assign mem_we = s_axis_tvalid && s_axis_tready;

    // ring address of window index iss_reg (index 0 at head)
    always_comb
    begin
        logic [CntW:0] sum;
        sum = {1'b0, CntW'(head_reg)} + {1'b0, iss_reg};
        if (sum >= (CntW+1)'(WINDOW_DEPTH))
            sum = sum - (CntW+1)'(WINDOW_DEPTH);
        rd_addr = IdxW'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[head_reg - ((head_reg == '0) ? IdxW'(0) : IdxW'(1))
                     + ((head_reg == '0) ? IdxW'(WINDOW_DEPTH - 1) : IdxW'(0))]
                <= bsd_pkg::hist_entry_t'({s_axis_tdata[75:64], s_axis_tdata[63:48],
                                           s_axis_tdata[47:32]});
        if (mem_re)
            rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            head_reg     <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                head_reg <= (head_reg == '0) ? IdxW'(WINDOW_DEPTH - 1) : head_reg - 1'b1;
                ring_vld_reg[(head_reg == '0) ? IdxW'(WINDOW_DEPTH - 1)
                             : head_reg - 1'b1] <= 1'b1;
            end
            if (mem_re)
                rd_vld_reg <= ring_vld_reg[rd_addr];
        end
    end

    // scan accumulators
    logic               have_s_reg, have_s_next;
    logic [CntW-1:0]    s_reg, s_next, e_reg, e_next;
    logic signed [15:0] px_reg, px_next, py_reg, py_next;
    logic signed [15:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [22:0]        path_reg, path_next;

    // bit-serial square root of a 34-bit radicand, two bits a step
    logic [33:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic [33:0] sq_val_reg, sq_val_next;

    // speed products
    logic [38:0] mul1_reg, mul1_next;
    logic [46:0] lhs_reg, lhs_next;
    logic [29:0] rhs_reg, rhs_next;

    // hold state
    logic [4:0]         hold_reg, hold_next;
    logic signed [15:0] spx_reg, spx_next, spy_reg, spy_next;
    logic signed [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]         verdict_reg, verdict_next;

    logic               entry_ok;
    logic signed [16:0] dx, dy;
    logic [33:0]        dsq;

    assign entry_ok = rd_vld_reg && (rd_data_reg.w > wthr_reg);
    assign dx  = 17'(px_reg) - 17'(signed'(rd_data_reg.x));
    assign dy  = 17'(py_reg) - 17'(signed'(rd_data_reg.y));
    assign dsq = 34'(dx * dx) + 34'(dy * dy);

    // nearest-point compare operands
    logic signed [16:0] cdx, cdy, bdx, bdy;
    logic [33:0]        cdsq, bdsq;
    assign cdx  = 17'(cx_reg) - 17'(rx_reg);
    assign cdy  = 17'(cy_reg) - 17'(ry_reg);
    assign bdx  = 17'(bx_reg) - 17'(rx_reg);
    assign bdy  = 17'(by_reg) - 17'(ry_reg);
    assign cdsq = 34'(cdx * cdx) + 34'(cdy * cdy);
    assign bdsq = 34'(bdx * bdx) + 34'(bdy * bdy);

    logic [33:0] trial;
    logic [4:0]  hold_dec;
    logic        span_ok;

    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        pos_next    = pos_reg;
        have_s_next = have_s_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        path_next   = path_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        sq_cnt_next = sq_cnt_reg;
        sq_val_next = sq_val_reg;
        mul1_next   = mul1_reg;
        lhs_next    = lhs_reg;
        rhs_next    = rhs_reg;
        hold_next   = hold_reg;
        spx_next    = spx_reg;
        spy_next    = spy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        verdict_next = verdict_reg;
        mem_re      = 1'b0;
        trial       = '0;
        hold_dec    = '0;
        span_ok     = have_s_reg && (e_reg > s_reg)
                      && (7'(e_reg - s_reg) > 7'(mspan_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next  = ST_READ;
                    iss_next    = '0;
                    have_s_next = 1'b0;
                    e_next      = '0;
                    s_next      = '0;
                    path_next   = '0;
                end
            end
            // issue the read of window index iss_reg
            ST_READ:
            begin
                mem_re    = 1'b1;
                pos_next  = iss_reg;
                iss_next  = iss_reg + 1'b1;
                state_next = ST_SCAN;
            end
            // look at entry pos_reg
            ST_SCAN:
            begin
                if (entry_ok)
                begin
                    px_next = signed'(rd_data_reg.x);
                    py_next = signed'(rd_data_reg.y);
                    if (!have_s_reg)
                    begin
                        have_s_next = 1'b1;
                        s_next      = pos_reg;
                    end
                    else
                    begin
                        e_next      = pos_reg;
                        ex_next     = signed'(rd_data_reg.x);
                        ey_next     = signed'(rd_data_reg.y);
                        sq_val_next = dsq;
                        rem_next    = '0;
                        root_next   = '0;
                        sq_cnt_next = 5'd16;
                    end
                end
                if (entry_ok && have_s_reg)
                    state_next = ST_SQRT;
                else if (iss_reg == CntW'(WINDOW_DEPTH))
                    state_next = ST_MUL1;
                else
                    state_next = ST_READ;
            end
            ST_SQRT:
            begin
                rem_next    = {rem_reg[31:0], sq_val_reg[33:32]};
                sq_val_next = {sq_val_reg[31:0], 2'b00};
                trial       = 34'({root_reg, 2'b01});
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_reg[15:0], 1'b1};
                end
                else
                    root_next = {root_reg[15:0], 1'b0};
                sq_cnt_next = sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == '0)
                begin
                    path_next = path_reg + 23'(root_next);
                    state_next = (iss_reg == CntW'(WINDOW_DEPTH)) ? ST_MUL1 : ST_READ;
                end
            end
            ST_MUL1:
            begin
                mul1_next  = 39'(path_reg) * 39'(dscale_reg);
                rhs_next   = 30'({sthr_reg, 8'd0}) * 30'(e_reg - s_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                lhs_next   = 47'(mul1_reg) * 47'(frate_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (span_ok)
                begin
                    if (lhs_reg > 47'(rhs_reg))
                    begin
                        if (hold_reg == '0)
                        begin
                            spx_next = ex_reg;
                            spy_next = ey_reg;
                            cx_next  = ex_reg;
                            cy_next  = ey_reg;
                        end
                        hold_next = hframes_reg;
                    end
                    else
                    begin
                        hold_dec  = (hold_reg != '0) ? hold_reg - 1'b1 : hold_reg;
                        hold_next = hold_dec;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // clamp, then nearest point
                if (hold_reg > hframes_reg)
                    hold_next = hframes_reg;
                if (hold_next == '0)
                begin
                    spx_next = '0;
                    spy_next = '0;
                    cx_next  = bx_reg;
                    cy_next  = by_reg;
                    verdict_next = bsd_pkg::VerdictIdle;
                end
                else if (cdsq > bdsq)
                begin
                    cx_next  = bx_reg;
                    cy_next  = by_reg;
                    verdict_next = bsd_pkg::VerdictNearer;
                end
                else
                    verdict_next = bsd_pkg::VerdictHeld;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    logic out_vld_reg;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, spy_reg, spx_reg, hold_reg, verdict_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            hold_reg    <= '0;
            spx_reg     <= '0;
            spy_reg     <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            verdict_reg <= bsd_pkg::VerdictIdle;
            iss_reg     <= '0;
        end
        else
        begin
            if (state_reg == ST_IDLE && !(s_axis_tvalid && s_axis_tready))
                state_reg <= ST_IDLE;
            else
                state_reg <= state_next;
            if (state_reg == ST_OUT)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
            hold_reg    <= hold_next;
            spx_reg     <= spx_next;
            spy_reg     <= spy_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            verdict_reg <= verdict_next;
            iss_reg     <= iss_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            rx_reg <= signed'(s_axis_tdata[15:0]);
            ry_reg <= signed'(s_axis_tdata[31:16]);
            bx_reg <= signed'(s_axis_tdata[47:32]);
            by_reg <= signed'(s_axis_tdata[63:48]);
        end
        pos_reg    <= pos_next;
        have_s_reg <= have_s_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        path_reg   <= path_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        sq_cnt_reg <= sq_cnt_next;
        sq_val_reg <= sq_val_next;
        mul1_reg   <= mul1_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
    end

    // assertions
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");
    a_idle_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && hold_reg == '0) |-> (spx_reg == '0 && spy_reg == '0))
        else $error("start point not cleared while idle");
    a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((hold_reg == '0) == (verdict_reg == bsd_pkg::VerdictIdle)))
        else $error("verdict and hold count disagree");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("frame taken while busy");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ball shot detector: frames are driven on the
// input stream under several idling and stall mixes, each result beat is
// compared with an in-bench model of the shot hold logic, and the registers
// are swept across their ranges between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int Depth      = bsd_pkg::WindowDepthDefault;
    localparam int DrainWait  = 19 * Depth + 40;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic signed [15:0] by;
        logic signed [15:0] bx;
        logic signed [15:0] ry;
        logic signed [15:0] rx;
    } frame_pos_t;

    typedef struct packed {
        logic [15:0] sy;
        logic [15:0] sx;
        logic [4:0]  hold;
        logic [1:0]  verdict;
    } shot_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // model registers and state
    logic [15:0] m_scale;
    logic [11:0] m_wthr;
    logic [5:0]  m_span;
    logic [7:0]  m_rate;
    logic [15:0] m_sthr;
    logic [4:0]  m_hold_frames;
    logic signed [15:0] win_x [Depth];
    logic signed [15:0] win_y [Depth];
    logic [11:0]        win_w [Depth];
    logic [4:0]         hold_cnt;
    logic signed [15:0] start_x, start_y, near_x, near_y;

    shot_result_t expected_results [$];

    int errors;
    int frames_sent;
    int results_seen;
    int verdict_seen [3];
    int idle_send_pct;
    int stall_pct;
    int long_stall;
    int quiet_cycles;

    ball_shot_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mismatch report
    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    function automatic logic [16:0] int_sqrt(input logic [33:0] v);
        logic [33:0] r;
        logic [33:0] b;
        r = '0;
        b = 34'h1 << 32;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[16:0];
    endfunction

    function automatic logic [33:0] sq_dist(input logic signed [15:0] ax,
        input logic signed [15:0] ay, input logic signed [15:0] bx,
        input logic signed [15:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return 34'(dx * dx + dy * dy);
    endfunction

    // shot hold prediction for one frame
    function automatic shot_result_t predict_shot(input frame_pos_t f, input logic [11:0] w);
        shot_result_t r;
        int newest;
        int oldest;
        logic signed [15:0] px, py;
        longint path;
        longint lhs;
        longint rhs;
        newest = -1;
        oldest = -1;
        px = 0;
        py = 0;
        path = 0;
        for (int i = Depth - 1; i > 0; i--)
        begin
            win_x[i] = win_x[i-1];
            win_y[i] = win_y[i-1];
            win_w[i] = win_w[i-1];
        end
        win_x[0] = f.bx;
        win_y[0] = f.by;
        win_w[0] = w;
        for (int i = 0; i < Depth; i++)
        begin
            if (win_w[i] > m_wthr)
            begin
                if (newest < 0)
                    newest = i;
                else
                begin
                    path += int_sqrt(sq_dist(px, py, win_x[i], win_y[i]));
                    oldest = i;
                end
                px = win_x[i];
                py = win_y[i];
            end
        end
        if (newest >= 0 && oldest >= 0 && oldest > newest + m_span)
        begin
            lhs = path * m_scale * m_rate;
            rhs = longint'(m_sthr) * (oldest - newest) * 256;
            if (lhs > rhs)
            begin
                if (hold_cnt == 0)
                begin
                    start_x = win_x[oldest];
                    start_y = win_y[oldest];
                    near_x = start_x;
                    near_y = start_y;
                end
                hold_cnt = m_hold_frames;
            end
            else
            begin
                if (hold_cnt > 0)
                    hold_cnt--;
                if (hold_cnt == 0)
                begin
                    start_x = 0;
                    start_y = 0;
                end
            end
        end
        if (hold_cnt > m_hold_frames)
            hold_cnt = m_hold_frames;
        if (hold_cnt == 0)
        begin
            start_x = 0;
            start_y = 0;
        end
        if (hold_cnt > 0)
        begin
            if (sq_dist(near_x, near_y, f.rx, f.ry) > sq_dist(f.bx, f.by, f.rx, f.ry))
            begin
                near_x = f.bx;
                near_y = f.by;
                r.verdict = bsd_pkg::VerdictNearer;
            end
            else
                r.verdict = bsd_pkg::VerdictHeld;
        end
        else
        begin
            near_x = f.bx;
            near_y = f.by;
            r.verdict = bsd_pkg::VerdictIdle;
        end
        r.hold = hold_cnt;
        r.sx = start_x;
        r.sy = start_y;
        return r;
    endfunction

    // send one frame and queue its expected result
    task automatic send_frame(input frame_pos_t f, input logic [11:0] w);
        while (idle_send_pct > 0 && $urandom_range(99, 0) < idle_send_pct)
            @(posedge clk);
        s_axis_tdata  <= {4'b0, w, f};
        s_axis_tvalid <= 1'b1;
        expected_results.push_back(predict_shot(f, w));
        frames_sent++;
        do
            @(posedge clk);
        while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
        // block is busy for this cycle anyway
        @(posedge clk);
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    // register write through the model and the cfg channel
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            bsd_pkg::RegDistanceScale:  m_scale = val;
            bsd_pkg::RegWidthThreshold: m_wthr = val[11:0];
            bsd_pkg::RegMinSpan:        m_span = val[5:0];
            bsd_pkg::RegFrameRate:      m_rate = val[7:0];
            bsd_pkg::RegSpeedThreshold: m_sthr = val;
            bsd_pkg::RegHoldFrames:     m_hold_frames = val[4:0];
            default: ;
        endcase
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] sc, input logic [11:0] wt, input logic [5:0] sp,
        input logic [7:0] fr, input logic [15:0] st, input logic [4:0] hf);
        drain();
        write_reg(bsd_pkg::RegDistanceScale, sc);
        write_reg(bsd_pkg::RegWidthThreshold, {4'b0, wt});
        write_reg(bsd_pkg::RegMinSpan, {10'b0, sp});
        write_reg(bsd_pkg::RegFrameRate, {8'b0, fr});
        write_reg(bsd_pkg::RegSpeedThreshold, st);
        write_reg(bsd_pkg::RegHoldFrames, {11'b0, hf});
    endtask

    // one throw: ball flies in a line from a start point, visible, with noise
    task automatic send_throw(input int len, input int step);
        frame_pos_t f;
        int sx, sy, vx, vy;
        logic [11:0] w;
        sx = $urandom_range(4000, 0) - 2000;
        sy = $urandom_range(4000, 0) - 2000;
        vx = $urandom_range(2 * step, 0) - step;
        vy = $urandom_range(2 * step, 0) - step;
        f.rx = 16'($urandom_range(2000, 0) - 1000);
        f.ry = 16'($urandom_range(2000, 0) - 1000);
        for (int i = 0; i < len; i++)
        begin
            f.bx = 16'(sx + vx * i);
            f.by = 16'(sy + vy * i);
            w = ($urandom_range(9, 0) == 0) ? 12'($urandom_range(20, 0))
                                            : 12'($urandom_range(4095, 11));
            send_frame(f, w);
        end
    endtask

    task automatic send_noise(input int n);
        frame_pos_t f;
        for (int i = 0; i < n; i++)
        begin
            f = {$urandom, $urandom};
            send_frame(f, 12'($urandom));
        end
    endtask

    // field extremes, hold and threshold edge cases
    task automatic test_directed();
        frame_pos_t f;
        f = {16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
        send_frame(f, 12'hfff);
        f = {16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        send_frame(f, 12'hfff);
        f = '0;
        send_frame(f, 12'd0);
        send_frame(f, 12'd10);
        send_frame(f, 12'd11);
        send_throw(12, 400);
        // threshold zero and full-range frames
        set_regs(16'hffff, 12'd0, 6'd0, 8'd255, 16'd0, 5'd31);
        send_throw(8, 3000);
        // hold zero, scale and rate zero
        set_regs(16'd0, 12'hfff, 6'd63, 8'd0, 16'hffff, 5'd0);
        send_noise(4);
        set_regs(bsd_pkg::DistanceScaleReset, bsd_pkg::WidthThresholdReset,
                 bsd_pkg::MinSpanReset, bsd_pkg::FrameRateReset,
                 bsd_pkg::SpeedThresholdReset, bsd_pkg::HoldFramesReset);
        write_reg(3'd7, 16'hffff);
    endtask

    // random phases under one idling mix
    task automatic test_random(input int send_pct, input int rcv_pct, input int throws);
        drain();
        idle_send_pct = send_pct;
        stall_pct = rcv_pct;
        for (int i = 0; i < throws; i++)
        begin
            if ($urandom_range(4, 0) == 0)
                send_noise($urandom_range(6, 1));
            else
                send_throw($urandom_range(30, 6), $urandom_range(600, 5));
        end
    endtask

    // long receiver hold-off so the block backs up, then a full pause
    task automatic test_back_pressure();
        drain();
        idle_send_pct = 0;
        stall_pct = 0;
        long_stall = 400;
        send_throw(10, 200);
        drain();
        send_throw(10, 200);
    endtask

    // receiver side: ready with random stalls, long hold-off counted here
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                long_stall--;
            end
            else
                m_axis_tready <= !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        shot_result_t got;
        shot_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[38:0];
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("result beat with nothing outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.verdict != want.verdict)
                    report_mismatch("verdict", got.verdict, want.verdict);
                if (got.hold != want.hold)
                    report_mismatch("hold_count", got.hold, want.hold);
                if (got.sx != want.sx)
                    report_mismatch("shot_start_x", $signed(got.sx), $signed(want.sx));
                if (got.sy != want.sy)
                    report_mismatch("shot_start_y", $signed(got.sy), $signed(want.sy));
                if (want.verdict <= bsd_pkg::VerdictNearer)
                    verdict_seen[want.verdict]++;
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        frames_sent = 0;
        results_seen = 0;
        idle_send_pct = 0;
        stall_pct = 0;
        long_stall = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 3; i++)
            verdict_seen[i] = 0;
        for (int i = 0; i < Depth; i++)
        begin
            win_x[i] = 0;
            win_y[i] = 0;
            win_w[i] = 0;
        end
        hold_cnt = 0;
        start_x = 0;
        start_y = 0;
        near_x = 0;
        near_y = 0;
        m_scale = bsd_pkg::DistanceScaleReset;
        m_wthr = bsd_pkg::WidthThresholdReset;
        m_span = bsd_pkg::MinSpanReset;
        m_rate = bsd_pkg::FrameRateReset;
        m_sthr = bsd_pkg::SpeedThresholdReset;
        m_hold_frames = bsd_pkg::HoldFramesReset;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 0, 20);
        set_regs(16'd512, 12'd100, 6'd2, 8'd30, 16'd500, 5'd7);
        test_random(46, 0, 20);
        set_regs(16'd64, 12'd5, 6'd10, 8'd120, 16'd3000, 5'd31);
        test_random(0, 46, 20);
        set_regs(16'd256, 12'd10, 6'd0, 8'd255, 16'd60000, 5'd1);
        test_random(6, 6, 20);
        set_regs(bsd_pkg::DistanceScaleReset, bsd_pkg::WidthThresholdReset,
                 bsd_pkg::MinSpanReset, bsd_pkg::FrameRateReset,
                 bsd_pkg::SpeedThresholdReset, bsd_pkg::HoldFramesReset);
        test_random(0, 0, 20);
        test_back_pressure();
        drain();

        $display("%0d frames sent, %0d results checked over six register settings",
                 frames_sent, results_seen);
        $display("verdicts seen: idle %0d, held %0d, nearer %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/bsd_pkg.sv
hw/rtl/ball_shot_detector.sv
tb/tb.sv
